>>> rtl/lad_pkg.sv
// ----------------------------------------------------------------------------
// lad_pkg
// Shared widths, codes, state encoding and bundle types of the lamp array
// color controller.
// ----------------------------------------------------------------------------
package lad_pkg;

  // Fixed field widths.
  localparam int KIND_W      = 2;
  localparam int ID_W        = 16;
  localparam int CH_W        = 8;
  localparam int COLOR_W     = 3 * CH_W;
  localparam int CNT_W       = 7;
  localparam int LAMP_IDX_W  = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Default store depth and register reset values.
  localparam int                MAX_LAMPS_DEF    = 64;
  localparam logic [CNT_W-1:0]  LAMP_COUNT_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GREEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BLUE  = 2'd3;

  // Item operations.
  typedef enum logic [KIND_W-1:0] {
    KIND_LAMP   = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_COMMIT = 2'd2,
    KIND_MODE   = 2'd3
  } kind_t;

  // Controller sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_COPY,
    ST_CLEAR,
    ST_FILL,
    ST_EMIT
  } ctl_state_t;

  // Read request for one frame entry, issued to the committed store.
  typedef struct packed {
    logic                  issue;
    logic [LAMP_IDX_W-1:0] idx;
    logic                  last;
  } emit_req_t;

  // One frame entry on its way to the result port.
  typedef struct packed {
    logic [LAMP_IDX_W-1:0] idx;
    logic [COLOR_W-1:0]    color;
    logic                  last;
  } frame_item_t;

endpackage

>>> rtl/lad_color_ram.sv
// ----------------------------------------------------------------------------
// lad_color_ram
// One color store: single write port, single registered read port, and a
// per-entry valid flag so that entries never written read as zero.
// ----------------------------------------------------------------------------
module lad_color_ram
  import lad_pkg::*;
#(
  parameter int DEPTH = MAX_LAMPS_DEF,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [COLOR_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [COLOR_W-1:0] rdata_r;

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
    end
  end

  // Valid flags: cleared by reset, set by the first write of an entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lad_frame_out.sv
// ----------------------------------------------------------------------------
// lad_frame_out
// Result stage: tracks the committed store read in flight and holds frame
// entries in an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module lad_frame_out
  import lad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  emit_req_t             req,
  input  logic [COLOR_W-1:0]    rdata,
  output logic                  slot_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LAMP_IDX_W-1:0] out_lamp_index,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic                  out_frame_end
);

  logic                  pend_r;
  logic [LAMP_IDX_W-1:0] pidx_r;
  logic                  plast_r;
  logic                  ov_r;
  frame_item_t           oitem_r;
  logic                  sv_r;
  frame_item_t           sitem_r;
  frame_item_t           arrive;
  logic                  pop;
  logic                  out_free;
  logic [1:0]            occ;

  assign pop      = ov_r && out_ready;
  assign out_free = !ov_r || out_ready;
  assign arrive   = '{idx: pidx_r, color: rdata, last: plast_r};

  // A new read may go out only if its data is sure to find a place.
  assign occ     = 2'(ov_r) + 2'(sv_r) + 2'(pend_r) - 2'(pop);
  assign slot_ok = (occ <= 2'd1);

  // Read in flight: the entry's data shows up in the cycle after the request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= req.issue;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= req.idx;
    plast_r <= req.last;
  end

  // Output register and skid entry, kept in arrival order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (out_free) begin
      if (sv_r) begin
        ov_r <= 1'b1;
        sv_r <= pend_r;
      end else begin
        ov_r <= pend_r;
      end
    end else if (pend_r) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sv_r) begin
        oitem_r <= sitem_r;
        sitem_r <= arrive;
      end else begin
        oitem_r <= arrive;
      end
    end else if (pend_r) begin
      sitem_r <= arrive;
    end
  end

  assign out_valid      = ov_r;
  assign out_lamp_index = oitem_r.idx;
  assign out_red        = oitem_r.color[3*CH_W-1:2*CH_W];
  assign out_green      = oitem_r.color[2*CH_W-1:CH_W];
  assign out_blue       = oitem_r.color[CH_W-1:0];
  assign out_frame_end  = oitem_r.last;

endmodule

>>> rtl/lad_ctrl.sv
// ----------------------------------------------------------------------------
// lad_ctrl
// Item sequencer: latches an item, scales its color, and walks the pending
// and committed stores for writes, range fills, commit copies, clears,
// idle fills and frame reads.
// ----------------------------------------------------------------------------
module lad_ctrl
  import lad_pkg::*;
#(
  parameter int MAX_LAMPS = MAX_LAMPS_DEF,
  parameter int AW        = 6,
  parameter int CW        = AW + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CW-1:0]      n_use,
  input  logic [COLOR_W-1:0] idle_color,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [ID_W-1:0]    in_lamp_id,
  input  logic [ID_W-1:0]    in_range_last,
  input  logic [CH_W-1:0]    in_red,
  input  logic [CH_W-1:0]    in_green,
  input  logic [CH_W-1:0]    in_blue,
  input  logic [CH_W-1:0]    in_intensity,
  input  logic               in_complete,
  input  logic               in_autonomous,
  output logic               pd_we,
  output logic [AW-1:0]      pd_waddr,
  output logic [COLOR_W-1:0] pd_wdata,
  output logic               pd_re,
  output logic [AW-1:0]      pd_raddr,
  input  logic [COLOR_W-1:0] pd_rdata,
  output logic               cm_we,
  output logic [AW-1:0]      cm_waddr,
  output logic [COLOR_W-1:0] cm_wdata,
  output logic               cm_re,
  output logic [AW-1:0]      cm_raddr,
  output emit_req_t          req,
  input  logic               slot_ok
);

  // floor(c * i / 255), exact for every product of two 8-bit channels.
  function automatic logic [CH_W-1:0] scale_chan(input logic [CH_W-1:0] c,
                                                 input logic [CH_W-1:0] i);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(c) * 16'(i);
    s = 17'(p) + 17'(p >> 8) + 17'd1;
    return s[15:8];
  endfunction

  ctl_state_t         state_r, state_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      end_r, end_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               mode_r, mode_nxt;
  logic               cp_pend_r;
  logic [AW-1:0]      cp_addr_r;

  kind_t              kind_r;
  logic [ID_W-1:0]    first_r;
  logic [ID_W-1:0]    last_r;
  logic [CH_W-1:0]    red_r, green_r, blue_r, inten_r;
  logic               complete_r;
  logic               auto_r;

  logic               accept;
  logic [CW-1:0]      n_m1;
  logic [ID_W-1:0]    last_cl;
  logic               first_in_n;
  logic               range_ok;
  logic               k_in_n;
  ctl_state_t         after_write;

  assign accept     = in_valid && in_ready;
  assign n_m1       = n_use - CW'(1);
  assign first_in_n = first_r < ID_W'(n_use);
  assign last_cl    = (last_r >= ID_W'(n_use)) ? ID_W'(n_m1) : last_r;
  assign range_ok   = first_r <= last_cl;
  assign k_in_n     = k_r < n_use;
  assign after_write = complete_r ? ST_COPY : ST_IDLE;

  // Next state and sequencer datapath.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    end_nxt   = end_r;
    color_nxt = color_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        color_nxt = {scale_chan(red_r, inten_r), scale_chan(green_r, inten_r),
                     scale_chan(blue_r, inten_r)};
        k_nxt     = '0;
        unique case (kind_r)
          KIND_LAMP: begin
            end_nxt = CW'(first_r);
            if (first_in_n) begin
              k_nxt     = CW'(first_r);
              state_nxt = ST_WRITE;
            end else begin
              state_nxt = after_write;
            end
          end
          KIND_RANGE: begin
            end_nxt = CW'(last_cl);
            if (range_ok) begin
              k_nxt     = CW'(first_r);
              state_nxt = ST_WRITE;
            end else begin
              state_nxt = after_write;
            end
          end
          KIND_COMMIT: begin
            state_nxt = ST_COPY;
          end
          KIND_MODE: begin
            if (mode_r && !auto_r) begin
              mode_nxt  = 1'b0;
              state_nxt = ST_CLEAR;
            end else if (!mode_r && auto_r) begin
              mode_nxt  = 1'b1;
              state_nxt = ST_FILL;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_WRITE: begin
        if (k_r == end_r) begin
          k_nxt     = '0;
          state_nxt = after_write;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      ST_COPY: begin
        if (k_in_n) begin
          k_nxt = k_r + CW'(1);
        end else begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_CLEAR, ST_FILL: begin
        if (k_r == n_m1) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      ST_EMIT: begin
        if (slot_ok) begin
          if (k_r == n_m1) begin
            k_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Store ports, frame read requests and input handshake.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    pd_we     = 1'b0;
    pd_waddr  = k_r[AW-1:0];
    pd_wdata  = color_r;
    pd_re     = 1'b0;
    pd_raddr  = k_r[AW-1:0];
    cm_we     = cp_pend_r;
    cm_waddr  = cp_pend_r ? cp_addr_r : k_r[AW-1:0];
    cm_wdata  = pd_rdata;
    cm_re     = 1'b0;
    cm_raddr  = k_r[AW-1:0];
    req.issue = 1'b0;
    req.idx   = LAMP_IDX_W'(k_r);
    req.last  = (k_r == n_m1);
    unique case (state_r)
      ST_WRITE: begin
        pd_we = 1'b1;
      end
      ST_COPY: begin
        pd_re = k_in_n;
      end
      ST_CLEAR: begin
        pd_we    = 1'b1;
        pd_wdata = '0;
        cm_we    = 1'b1;
        cm_wdata = '0;
      end
      ST_FILL: begin
        cm_we    = 1'b1;
        cm_wdata = idle_color;
      end
      ST_EMIT: begin
        cm_re     = slot_ok;
        req.issue = slot_ok;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      k_r       <= '0;
      mode_r    <= 1'b1;
      cp_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      mode_r    <= mode_nxt;
      cp_pend_r <= (state_r == ST_COPY) && k_in_n;
    end
  end

  // Item and datapath registers.
  always_ff @(posedge clk) begin
    end_r     <= end_nxt;
    color_r   <= color_nxt;
    cp_addr_r <= k_r[AW-1:0];
    if (accept) begin
      kind_r     <= kind_t'(in_kind);
      first_r    <= in_lamp_id;
      last_r     <= in_range_last;
      red_r      <= in_red;
      green_r    <= in_green;
      blue_r     <= in_blue;
      inten_r    <= in_intensity;
      complete_r <= in_complete;
      auto_r     <= in_autonomous;
    end
  end

endmodule

>>> rtl/lamp_array_double_buffered_colors.sv
// ----------------------------------------------------------------------------
// lamp_array_double_buffered_colors
// Lamp color controller with a pending and a committed color store. Items
// write one lamp or a range of lamps into pending (colors scaled by
// intensity), commit pending to committed, or switch autonomous mode, which
// clears both stores on leaving and fills committed with the idle color on
// entering. Each change to committed sends the whole frame out, one result
// per lamp in use, lamp 0 first, frame_end on the last. One item is handled
// at a time. A commit copies pending into committed, read out of pending one
// lamp a cycle, and then sends the frame, read from the committed store one
// lamp a cycle while the result stage has room; clear and idle fill write
// every lamp in use and then send the frame the same way. The output
// register and a skid entry let the next item start while the last
// entries of a frame wait to be taken. Per-entry valid flags make both
// stores read as zero right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module lamp_array_double_buffered_colors
  import lad_pkg::*;
#(
  parameter int MAX_LAMPS = MAX_LAMPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [ID_W-1:0]       in_lamp_id,
  input  logic [ID_W-1:0]       in_range_last,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_intensity,
  input  logic                  in_complete,
  input  logic                  in_autonomous,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LAMP_IDX_W-1:0] out_lamp_index,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic                  out_frame_end
);

  localparam int AW = (MAX_LAMPS > 1) ? $clog2(MAX_LAMPS) : 1;
  localparam int CW = AW + 1;

  logic [CNT_W-1:0]   lamp_count_r;
  logic [CH_W-1:0]    idle_red_r, idle_green_r, idle_blue_r;
  logic [CW-1:0]      n_use;

  logic               pd_we, pd_re, cm_we, cm_re;
  logic [AW-1:0]      pd_waddr, pd_raddr, cm_waddr, cm_raddr;
  logic [COLOR_W-1:0] pd_wdata, pd_rdata, cm_wdata, cm_rdata;
  emit_req_t          req;
  logic               slot_ok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_count_r <= LAMP_COUNT_RESET;
      idle_red_r   <= '0;
      idle_green_r <= '0;
      idle_blue_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAMP_COUNT: lamp_count_r <= cfg_data[CNT_W-1:0];
        CFG_IDLE_RED:   idle_red_r   <= cfg_data;
        CFG_IDLE_GREEN: idle_green_r <= cfg_data;
        CFG_IDLE_BLUE:  idle_blue_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Lamps in use: the count held to the range one to the store depth.
  always_comb begin
    if (lamp_count_r == '0) begin
      n_use = CW'(1);
    end else if (lamp_count_r > CNT_W'(MAX_LAMPS)) begin
      n_use = CW'(MAX_LAMPS);
    end else begin
      n_use = CW'(lamp_count_r);
    end
  end

  lad_ctrl #(
    .MAX_LAMPS(MAX_LAMPS),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .n_use        (n_use),
    .idle_color   ({idle_red_r, idle_green_r, idle_blue_r}),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_lamp_id   (in_lamp_id),
    .in_range_last(in_range_last),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_intensity (in_intensity),
    .in_complete  (in_complete),
    .in_autonomous(in_autonomous),
    .pd_we        (pd_we),
    .pd_waddr     (pd_waddr),
    .pd_wdata     (pd_wdata),
    .pd_re        (pd_re),
    .pd_raddr     (pd_raddr),
    .pd_rdata     (pd_rdata),
    .cm_we        (cm_we),
    .cm_waddr     (cm_waddr),
    .cm_wdata     (cm_wdata),
    .cm_re        (cm_re),
    .cm_raddr     (cm_raddr),
    .req          (req),
    .slot_ok      (slot_ok)
  );

  // Pending store.
  lad_color_ram #(
    .DEPTH(MAX_LAMPS),
    .AW   (AW)
  ) u_pending (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (pd_we),
    .waddr(pd_waddr),
    .wdata(pd_wdata),
    .re   (pd_re),
    .raddr(pd_raddr),
    .rdata(pd_rdata)
  );

  // Committed store.
  lad_color_ram #(
    .DEPTH(MAX_LAMPS),
    .AW   (AW)
  ) u_committed (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (cm_we),
    .waddr(cm_waddr),
    .wdata(cm_wdata),
    .re   (cm_re),
    .raddr(cm_raddr),
    .rdata(cm_rdata)
  );

  lad_frame_out u_frame_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .rdata         (cm_rdata),
    .slot_ok       (slot_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_lamp_index(out_lamp_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an accepted item");

  // The frame is never read from the committed store while it is written.
  a_no_commit_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cm_we && cm_re))
    else $error("committed store written during frame read");

  // Inside a frame, the entry after a taken one drives the next lamp.
  a_lamp_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_frame_end) ##1 out_valid |->
      out_lamp_index == $past(out_lamp_index) + 6'd1)
    else $error("frame entries out of lamp order");
`endif

endmodule
